@@ hw/rtl/mscs_pkg.sv @@
// shared types and constants for the moisture sensor calibrate and scale block
`timescale 1ns / 1ps

package mscs_pkg;

  localparam int SampleBits  = 12;
  localparam int PeriodBits  = 20;
  localparam int PctBits     = 7;
  localparam int CfgIdxBits  = 4;
  localparam int CfgDataBits = 20;
  // |s - low| * 100 fits in 19 bits for 12-bit readings
  localparam int DivBits     = 19;
  localparam int CntBits     = $clog2(DivBits);

  localparam logic [PeriodBits-1:0] PeriodReset  = PeriodBits'(20000);
  localparam logic [PeriodBits-1:0] ElapsedMax   = {PeriodBits{1'b1}};
  localparam logic [SampleBits-1:0] LowReset     = {SampleBits{1'b1}};
  localparam logic [SampleBits-1:0] HighReset    = '0;
  localparam logic [PctBits-1:0]    PctFull      = PctBits'(100);
  localparam logic [CntBits-1:0]    DivLastCount = CntBits'(DivBits - 1);

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_TICK   = 2'd1,
    OP_SAMPLE = 2'd2
  } op_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_PERIOD     = 4'd0,
    CFG_STORED_CAL = 4'd1,
    CFG_STORED_LOW = 4'd2,
    CFG_STORED_HIGH = 4'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]            op;
    logic [SampleBits-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic                  phase;
    logic [PctBits-1:0]    percent;
    logic [SampleBits-1:0] raw;
    logic [SampleBits-1:0] low_bound;
    logic [SampleBits-1:0] high_bound;
  } out_item_t;

  typedef struct packed {
    logic begin_load;
    logic tick;
    logic capture;
    logic cal_update;
    logic prep;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic calibrated;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

@@ hw/rtl/mscs_ctrl.sv @@
// controller state machine: input handshake and sequencing of the datapath
`timescale 1ns / 1ps

module mscs_ctrl import mscs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_op_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o,
  output logic       in_stall_o
);

  state_e state_q, state_d;
  logic   accept;

  assign accept = (state_q == ST_IDLE) && in_valid_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_op_i == OP_SAMPLE)) begin
          state_d = sts_i.calibrated ? ST_PREP : ST_EMIT;
        end
      end
      ST_PREP: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        cmd_o.begin_load = accept && (in_op_i == OP_BEGIN);
        cmd_o.tick       = accept && (in_op_i == OP_TICK);
        cmd_o.capture    = accept && (in_op_i == OP_SAMPLE);
        cmd_o.cal_update = accept && (in_op_i == OP_SAMPLE) && !sts_i.calibrated;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.emit = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hw/rtl/mscs_dp.sv @@
// datapath: configuration, calibration state, serial divider and result register
`timescale 1ns / 1ps

module mscs_dp import mscs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  input  logic [SampleBits-1:0]  in_sample_i,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  output out_item_t              out_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i
);

  // configuration
  logic [PeriodBits-1:0] period_q;
  logic                  st_cal_q;
  logic [SampleBits-1:0] st_low_q, st_high_q;

  // calibration state
  logic                  cal_q;
  logic [SampleBits-1:0] low_q, high_q;
  logic [PeriodBits-1:0] elapsed_q;
  logic [PeriodBits-1:0] elapsed_inc;

  // working registers
  logic [SampleBits-1:0] samp_q;
  logic                  neg_q, equal_q;
  logic [SampleBits-1:0] dmag_q;
  logic [SampleBits-1:0] rem_q, rem_d;
  logic [DivBits-1:0]    quo_q, quo_d;
  logic [CntBits-1:0]    cnt_q;

  logic [SampleBits-1:0] diff_mag;
  logic [DivBits-1:0]    diff_ext, num_mag;
  logic [SampleBits:0]   shifted;
  logic [PctBits-1:0]    pct;

  out_item_t out_q;
  logic      out_valid_q;

  assign elapsed_inc = (elapsed_q == ElapsedMax) ? elapsed_q : elapsed_q + 1'b1;

  // magnitude of the numerator: |s - low| * 100 as shifts and adds
  assign diff_mag = (samp_q >= low_q) ? (samp_q - low_q) : (low_q - samp_q);
  assign diff_ext = DivBits'(diff_mag);
  assign num_mag  = (diff_ext << 6) + (diff_ext << 5) + (diff_ext << 2);

  // restoring division, one quotient bit per cycle
  assign shifted = {rem_q, quo_q[DivBits-1]};
  always_comb begin
    if (shifted >= {1'b0, dmag_q}) begin
      rem_d = SampleBits'(shifted - {1'b0, dmag_q});
      quo_d = {quo_q[DivBits-2:0], 1'b1};
    end else begin
      rem_d = shifted[SampleBits-1:0];
      quo_d = {quo_q[DivBits-2:0], 1'b0};
    end
  end

  // 100 plus signed quotient clamped to 0..100; 0 if uncalibrated or low == high
  always_comb begin
    if (!cal_q || equal_q) begin
      pct = '0;
    end else if (!neg_q) begin
      pct = PctFull;
    end else if (quo_q < DivBits'(PctFull)) begin
      pct = PctFull - quo_q[PctBits-1:0];
    end else begin
      pct = '0;
    end
  end

  assign sts_o.calibrated = cal_q;
  assign sts_o.div_done   = (cnt_q == DivLastCount);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= PeriodReset;
      st_cal_q    <= 1'b0;
      st_low_q    <= LowReset;
      st_high_q   <= HighReset;
      cal_q       <= 1'b0;
      low_q       <= LowReset;
      high_q      <= HighReset;
      elapsed_q   <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PERIOD:      period_q  <= cfg_data_i[PeriodBits-1:0];
          CFG_STORED_CAL:  st_cal_q  <= cfg_data_i[0];
          CFG_STORED_LOW:  st_low_q  <= cfg_data_i[SampleBits-1:0];
          CFG_STORED_HIGH: st_high_q <= cfg_data_i[SampleBits-1:0];
          default: ;
        endcase
      end
      if (cmd_i.begin_load) begin
        low_q     <= st_low_q;
        high_q    <= st_high_q;
        elapsed_q <= '0;
        // a zero period ends the phase at once
        cal_q     <= st_cal_q || (period_q == '0);
      end
      if (cmd_i.tick && !cal_q) begin
        elapsed_q <= elapsed_inc;
        cal_q     <= (elapsed_inc >= period_q);
      end
      if (cmd_i.cal_update) begin
        if (in_sample_i > high_q) begin
          high_q <= in_sample_i;
        end
        if (in_sample_i < low_q) begin
          low_q <= in_sample_i;
        end
      end
      if (cmd_i.prep) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      samp_q <= in_sample_i;
    end
    if (cmd_i.prep) begin
      // quotient counts as negative when the numerator and divisor signs agree
      neg_q   <= (samp_q > low_q) ^ (low_q > high_q);
      equal_q <= (low_q == high_q);
      dmag_q  <= (high_q >= low_q) ? (high_q - low_q) : (low_q - high_q);
      rem_q   <= '0;
      quo_q   <= num_mag;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    if (cmd_i.emit) begin
      out_q.phase      <= cal_q;
      out_q.percent    <= pct;
      out_q.raw        <= samp_q;
      out_q.low_bound  <= low_q;
      out_q.high_bound <= high_q;
    end
  end

  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

endmodule

@@ hw/rtl/moisture_sensor_calibrate_scale.sv @@
// Moisture sensor conditioner: min/max calibration and percent scaling.
// Begin, tick and unused ops give no result and leave the input ready for the next item.
// A calibration sample goes from idle straight to the emit state; a measured sample
// passes prep, divide and emit; the restoring divider gives one quotient bit a cycle.
// The next item is taken as soon as the result sits in the output register.
// Asynchronous active-low reset restores configuration defaults and calibration state.
`timescale 1ns / 1ps

module moisture_sensor_calibrate_scale import mscs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  in_item_t               in_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output out_item_t              out_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  mscs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_i.op),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  mscs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_sample_i (in_i.sample),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_o       (out_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  // items other than samples leave the block ready for the next transfer
  a_nonsample_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_i.op != OP_SAMPLE) |=> !in_stall_o)
    else $error("non-sample item held the input");

  // a sample always keeps the input stalled in the cycle after its transfer
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_i.op == OP_SAMPLE) |=> in_stall_o)
    else $error("sample did not occupy the block");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.percent <= PctFull))
    else $error("percent out of range");

  a_cal_pct_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.phase |-> (out_o.percent == '0))
    else $error("non-zero percent during calibration");

endmodule
